[rtl/csq_pkg.sv]
package csq_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 32;
  localparam int unsigned WORD_BITS_DEFAULT = 32;

  // operation codes
  typedef enum logic [3:0] {
    OP_START        = 4'd0,
    OP_END          = 4'd1,
    OP_LAST         = 4'd2,
    OP_ADVANCE      = 4'd3,
    OP_RETREAT      = 4'd4,
    OP_INSERT       = 4'd5,
    OP_INSERT_FRONT = 4'd6,
    OP_ATTACH       = 4'd7,
    OP_ATTACH_BACK  = 4'd8,
    OP_REMOVE_CUR   = 4'd9,
    OP_REMOVE_FRONT = 4'd10,
    OP_READ         = 4'd11
  } op_t;

  // result error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RANGE = 2'd3
  } err_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage

[rtl/csq_cell.sv]
module csq_cell
  import csq_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 5,
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic [IDX_W-1:0]     pos,
  input  logic [WORD_BITS-1:0] word_in,
  input  logic [WORD_BITS-1:0] prev_word,
  input  logic [WORD_BITS-1:0] next_word,
  output logic [WORD_BITS-1:0] word
);

  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);

  logic [WORD_BITS-1:0] word_next;

  always_comb begin
    priority if (cmd.load && (MY_SLOT == pos)) begin
      word_next = word_in;
    end else if (cmd.shift_up && (MY_SLOT > pos)) begin
      word_next = prev_word;
    end else if (cmd.shift_down && (MY_SLOT >= pos)) begin
      word_next = next_word;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

[rtl/cursor_sequence_store.sv]
// cursor_sequence_store: ordered list of data words with a count and a cursor
// the result of an operation is presented in the cycle after its transfer
// throughput: one operation per cycle while results are taken; the row of cells shifts every entry in
// parallel, so inserts and removals finish in the same cycle as cursor moves
// reset (synchronous, active high) empties the list and puts the cursor at slot 0;
// entry contents stay undefined until written
module cursor_sequence_store
  import csq_pkg::*;
#(
  parameter int unsigned CAPACITY_ENTRIES = CAPACITY_DEFAULT,
  parameter int unsigned WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // operation channel
  input  logic        op_valid,
  output logic        op_ready,
  input  logic [3:0]  operation,
  input  logic [31:0] item_value,
  input  logic [4:0]  read_index,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] current_value,
  output logic        current_valid,
  output logic [5:0]  item_count,
  output logic [31:0] read_value,
  output logic [1:0]  error_code
);

  // slot index and count widths
  localparam int unsigned IDX_W = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY_ENTRIES + 1);
  // width wide enough to compare the read index against the count
  localparam int unsigned RD_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY_ENTRIES - 1);

  // list control state
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] cursor, cursor_next;

  // per-result registers; the other result fields are read back from the cells
  // and from count and cursor, which hold still while a result waits
  err_t             err_code, err_code_next;
  logic             read_ok, read_ok_next;
  logic [IDX_W-1:0] read_slot;

  logic op_xfer;
  logic has_current;
  logic full;
  logic empty;

  cell_cmd_t        cmd, cmd_apply;
  logic [IDX_W-1:0] pos;

  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] words [CAPACITY_ENTRIES];

  logic [63:0] cur_wide;
  logic [63:0] rd_wide;

  // the output register parts the two sides: a new operation is taken
  // whenever the slot is free or the waiting result leaves this cycle
  assign op_ready = !res_valid || res_ready;
  assign op_xfer  = op_valid && op_ready;

  assign has_current = {{(CNT_W-IDX_W){1'b0}}, cursor} < count;
  assign full        = (count == FULL_COUNT);
  assign empty       = (count == '0);

  // incoming word masked to the stored width
  assign new_word = WORD_BITS'(item_value);

  // decode: next count and cursor, error, and the command for the cell row
  always_comb begin
    count_next    = count;
    cursor_next   = cursor;
    err_code_next = ERR_OK;
    read_ok_next  = 1'b0;
    cmd           = '0;
    pos           = '0;
    unique case (op_t'(operation))
      OP_START: begin
        cursor_next = '0;
      end
      OP_END: begin
        if (empty) begin
          err_code_next = ERR_EMPTY;
        end else begin
          cursor_next = IDX_W'(count - 1'b1);
        end
      end
      OP_LAST: begin
        cursor_next = LAST_SLOT;
      end
      OP_ADVANCE: begin
        if (!has_current) begin
          err_code_next = ERR_EMPTY;
        end else if (cursor < LAST_SLOT) begin
          cursor_next = cursor + 1'b1;
        end
      end
      OP_RETREAT: begin
        if (cursor != '0) begin
          cursor_next = cursor - 1'b1;
        end
      end
      OP_INSERT, OP_INSERT_FRONT: begin
        if (full) begin
          err_code_next = ERR_FULL;
        end else begin
          // open a gap at the cursor, or at the front for insert-front or without a current item
          cmd.load     = 1'b1;
          cmd.shift_up = 1'b1;
          count_next   = count + 1'b1;
          if ((op_t'(operation) == OP_INSERT) && has_current) begin
            pos = cursor;
          end else begin
            pos         = '0;
            cursor_next = '0;
          end
        end
      end
      OP_ATTACH, OP_ATTACH_BACK: begin
        if (full) begin
          err_code_next = ERR_FULL;
        end else begin
          cmd.load   = 1'b1;
          count_next = count + 1'b1;
          if ((op_t'(operation) == OP_ATTACH) && has_current) begin
            // gap right after the cursor, cursor follows the new word
            cmd.shift_up = 1'b1;
            pos          = cursor + 1'b1;
            cursor_next  = cursor + 1'b1;
          end else begin
            // append after the last item
            pos         = IDX_W'(count);
            cursor_next = IDX_W'(count);
          end
        end
      end
      OP_REMOVE_CUR: begin
        if (!has_current) begin
          err_code_next = ERR_EMPTY;
        end else begin
          // close the gap over the cursor slot; cursor keeps its slot
          cmd.shift_down = 1'b1;
          pos            = cursor;
          count_next     = count - 1'b1;
        end
      end
      OP_REMOVE_FRONT: begin
        if (empty) begin
          err_code_next = ERR_EMPTY;
        end else begin
          cmd.shift_down = 1'b1;
          pos            = '0;
          count_next     = count - 1'b1;
        end
      end
      OP_READ: begin
        // an index below the count is always inside the row
        if (RD_W'(read_index) < RD_W'(count)) begin
          read_ok_next = 1'b1;
        end else begin
          err_code_next = ERR_RANGE;
        end
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase
  end

  // cells only move on a transfer
  assign cmd_apply = op_xfer ? cmd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (op_xfer) begin
        count     <= count_next;
        cursor    <= cursor_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_xfer) begin
      err_code  <= err_code_next;
      read_ok   <= read_ok_next;
      read_slot <= IDX_W'(read_index);
    end
  end

  // row of cells: each takes the new word, its lower neighbor or its upper
  // neighbor, or holds
  for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w;
    logic [WORD_BITS-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_inner_lo
      assign prev_w = words[i-1];
    end

    if (i == CAPACITY_ENTRIES - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner_hi
      assign next_w = words[i+1];
    end

    csq_cell #(
      .INDEX     (i),
      .IDX_W     (IDX_W),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd_apply),
      .pos       (pos),
      .word_in   (new_word),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (words[i])
    );
  end

  // result fields read back from the state left by the operation
  assign cur_wide = has_current ? 64'(words[cursor]) : 64'd0;
  assign rd_wide  = read_ok ? 64'(words[read_slot]) : 64'd0;

  assign current_value = cur_wide[31:0];
  assign current_valid = has_current;
  assign item_count    = 6'(count);
  assign read_value    = rd_wide[31:0];
  assign error_code    = err_code;

endmodule
